FILE: src/double_ended_buffer_with_filter_assert.svh
// Assertion macros used by the double-ended buffer RTL.
`ifndef DOUBLE_ENDED_BUFFER_WITH_FILTER_ASSERT_SVH
`define DOUBLE_ENDED_BUFFER_WITH_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DEBF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("double-ended buffer: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define DEBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("double-ended buffer: next-cycle check failed");

`endif

FILE: src/debf_pkg.sv
// Package with the types, constants and ring helpers of the double-ended buffer.
`default_nettype none

package debf_pkg;

   localparam int DEPTH  = 64;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int FILL_W = 7;

   localparam logic signed [DATA_W-1:0] EMPTY_WORD = -32'sd1;

   typedef enum logic [1:0] {
      ACT_PUSH_BACK = 2'd0,
      ACT_POP_BACK  = 2'd1,
      ACT_POP_FRONT = 2'd2,
      ACT_REMOVE    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      action_type               action;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      status_type               status;
      logic [FILL_W-1:0]        fill;
      logic                     vacant;
   } rsp_type;

   // Requests from the sequencer to the ring pointer unit.
   typedef struct packed {
      logic             push;
      logic             drop_back;
      logic             drop_front;
      logic             load;
      logic [PTR_W-1:0] load_tail;
      logic [CNT_W-1:0] load_occ;
   } ptr_ctl_type;

   // Current ring position and fill as seen by the sequencer.
   typedef struct packed {
      logic [PTR_W-1:0] head;
      logic [PTR_W-1:0] tail;
      logic [PTR_W-1:0] tail_prev;
      logic [CNT_W-1:0] occ;
   } ptr_state_type;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
   endfunction

endpackage

`default_nettype wire

FILE: src/double_ended_buffer_with_filter.sv
// Top level of the double-ended buffer with remove-all-matching filter.
//
//   channel   ports                       handshake
//   request   start, busy, req_payload    taken when start is high and busy is low
//   response  rsp_strobe, rsp_payload     one word per request, valid one cycle
//
// Push, pop back and pop front take one cycle each: busy stays low, so a new request may
// be taken at the next edge, and the response is strobed in the cycle after the request.
// A remove walks the held words through the store's single read port, one word a cycle;
// busy stays high for the walk and the response is strobed in the cycle after the last
// word; a remove on an empty buffer leaves busy low and is answered like a pop. Reset is
// synchronous and clears the pointers, fill count and sequencer. The receiver cannot stall.
`default_nettype none

module double_ended_buffer_with_filter
   import debf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_payload,
   output logic         rsp_strobe,
   output rsp_type      rsp_payload
);

`include "double_ended_buffer_with_filter_assert.svh"

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_WALK = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // The word store: one write port and one registered read port.
   logic signed [DATA_W-1:0] mem [DEPTH];
   logic                     mem_we;
   logic [PTR_W-1:0]         mem_waddr;
   logic signed [DATA_W-1:0] mem_wdata;
   logic                     mem_re;
   logic [PTR_W-1:0]         mem_raddr;
   logic signed [DATA_W-1:0] rd_data_ff;

   // Walk state for a remove: read and write positions, the index of the word
   // now on the read port, the count of words kept so far and the word to drop.
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         kept_ff, kept_in;
   logic signed [DATA_W-1:0] match_ff, match_in;

   // Response registers; a pop takes its data straight from the read register.
   logic    rsp_strobe_ff, rsp_strobe_in;
   logic    rsp_mem_ff, rsp_mem_in;
   rsp_type rsp_ff, rsp_in;

   ptr_ctl_type   ptr_ctl;
   ptr_state_type ptr;

   logic             accept;
   logic             is_full;
   logic             is_void;
   logic             hit;
   logic             last;
   logic [CNT_W-1:0] kept_next;

   debf_ring_ptr u_ring_ptr (
      .clock (clock),
      .reset (reset),
      .ctl   (ptr_ctl),
      .state (ptr)
   );

   assign busy    = (state_ff == S_WALK);
   assign accept  = start && !busy;
   assign is_full = (ptr.occ == CNT_W'(DEPTH));
   assign is_void = (ptr.occ == '0);

   // During a walk, the read register holds the word at position idx_ff.
   assign hit       = (rd_data_ff == match_ff);
   assign last      = ((CNT_W'(idx_ff) + CNT_W'(1)) == ptr.occ);
   assign kept_next = hit ? kept_ff : kept_ff + CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      mem_we        = 1'b0;
      mem_waddr     = wr_ptr_ff;
      mem_wdata     = rd_data_ff;
      mem_re        = 1'b0;
      mem_raddr     = rd_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      idx_in        = idx_ff;
      kept_in       = kept_ff;
      match_in      = match_ff;
      ptr_ctl       = '0;
      rsp_strobe_in = 1'b0;
      rsp_mem_in    = 1'b0;
      rsp_in.data   = '0;
      rsp_in.status = ST_OK;
      rsp_in.fill   = FILL_W'(ptr.occ);
      rsp_in.vacant = is_void;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_payload.action)
                  ACT_PUSH_BACK: begin
                     rsp_strobe_in = 1'b1;
                     if (is_full) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        mem_we        = 1'b1;
                        mem_waddr     = ptr.tail;
                        mem_wdata     = req_payload.value;
                        ptr_ctl.push  = 1'b1;
                        rsp_in.fill   = FILL_W'(ptr.occ + CNT_W'(1));
                        rsp_in.vacant = 1'b0;
                     end
                  end
                  ACT_POP_BACK, ACT_POP_FRONT: begin
                     rsp_strobe_in = 1'b1;
                     if (is_void) begin
                        rsp_in.data   = EMPTY_WORD;
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        mem_re     = 1'b1;
                        rsp_mem_in = 1'b1;
                        if (req_payload.action == ACT_POP_BACK) begin
                           mem_raddr         = ptr.tail_prev;
                           ptr_ctl.drop_back = 1'b1;
                        end else begin
                           mem_raddr          = ptr.head;
                           ptr_ctl.drop_front = 1'b1;
                        end
                        rsp_in.fill   = FILL_W'(ptr.occ - CNT_W'(1));
                        rsp_in.vacant = (ptr.occ == CNT_W'(1));
                     end
                  end
                  ACT_REMOVE: begin
                     if (is_void) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        // Start the walk: read the front word now.
                        mem_re    = 1'b1;
                        mem_raddr = ptr.head;
                        rd_ptr_in = ptr_inc(ptr.head);
                        wr_ptr_in = ptr.head;
                        idx_in    = '0;
                        kept_in   = '0;
                        match_in  = req_payload.value;
                        state_in  = S_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WALK: begin
            // A word that survives is packed back at the write position. The write
            // position never passes the read position, so the two never collide.
            if (!hit) begin
               mem_we    = 1'b1;
               mem_waddr = wr_ptr_ff;
               mem_wdata = rd_data_ff;
               wr_ptr_in = ptr_inc(wr_ptr_ff);
            end
            kept_in = kept_next;
            if (!last) begin
               mem_re    = 1'b1;
               mem_raddr = rd_ptr_ff;
               rd_ptr_in = ptr_inc(rd_ptr_ff);
               idx_in    = idx_ff + PTR_W'(1);
            end else begin
               // The new tail is the slot after the last word kept.
               ptr_ctl.load      = 1'b1;
               ptr_ctl.load_tail = hit ? wr_ptr_ff : ptr_inc(wr_ptr_ff);
               ptr_ctl.load_occ  = kept_next;
               rsp_strobe_in     = 1'b1;
               rsp_in.fill       = FILL_W'(kept_next);
               rsp_in.vacant     = (kept_next == '0);
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Store write and registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         rsp_mem_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_mem_ff    <= rsp_mem_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      wr_ptr_ff <= wr_ptr_in;
      idx_ff    <= idx_in;
      kept_ff   <= kept_in;
      match_ff  <= match_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      rsp_payload = rsp_ff;
      if (rsp_mem_ff) begin
         rsp_payload.data = rd_data_ff;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;

   // Every request is either answered in the next cycle or starts a walk.
   `DEBF_ASSERT_NEXT(a_accept_answered, clock, reset, accept, rsp_strobe || busy)
   // No response leaves while a walk is under way.
   `DEBF_ASSERT_NOW(a_no_rsp_in_walk, clock, reset, busy, !rsp_strobe)
   // A refused push is only reported when the ring is full.
   `DEBF_ASSERT_NOW(a_full_fill, clock, reset,
      rsp_strobe && (rsp_payload.status == ST_FULL), ptr.occ == CNT_W'(DEPTH))

endmodule

`default_nettype wire

FILE: src/debf_ring_ptr.sv
// Head, tail and occupancy registers of the ring.
`default_nettype none

module debf_ring_ptr
   import debf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ptr_ctl_type   ctl,
   output ptr_state_type      state
);

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] occ_ff, occ_in;

   // The tail points at the first free slot, one past the back word.
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      occ_in  = occ_ff;
      if (ctl.load) begin
         tail_in = ctl.load_tail;
         occ_in  = ctl.load_occ;
      end else if (ctl.push) begin
         tail_in = ptr_inc(tail_ff);
         occ_in  = occ_ff + CNT_W'(1);
      end else if (ctl.drop_back) begin
         tail_in = ptr_dec(tail_ff);
         occ_in  = occ_ff - CNT_W'(1);
      end else if (ctl.drop_front) begin
         head_in = ptr_inc(head_ff);
         occ_in  = occ_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
      end
   end

   assign state.head      = head_ff;
   assign state.tail      = tail_ff;
   assign state.tail_prev = ptr_dec(tail_ff);
   assign state.occ       = occ_ff;

endmodule

`default_nettype wire

FILE: tb/double_ended_buffer_with_filter_test.sv
// Self-checking testbench for the double-ended buffer with remove-all-matching filter.
`timescale 1ns / 100ps

module double_ended_buffer_with_filter_test
   import debf_pkg::*;
;

   // Clock, reset and the request side are driven from the first edge onwards.
   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    start       = 1'b0;
   req_type req_payload = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   double_ended_buffer_with_filter i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // Our own picture of the buffer. It is updated when a request word is
   // taken, so it always describes the block as it stands after that word.
   logic signed [DATA_W-1:0] model_ring [DEPTH];
   int                       model_head  = 0;
   int                       model_count = 0;

   // Responses that the block still owes us, oldest first.
   rsp_type awaited_rsp [$];

   // Percentage of cycles in which the sender holds back a request word.
   int sender_idle_pct = 0;

   // Statistics for the closing summary.
   int mismatches   = 0;
   int words_sent   = 0;
   int words_seen   = 0;
   int full_refused = 0;
   int empty_pops   = 0;
   int removals     = 0;
   int max_count    = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   // Work out the response to one operation and move the buffer picture on.
   // The ring wraps modulo DEPTH, so front space freed by pops is reused.
   function automatic rsp_type apply_operation(input req_type w);
      rsp_type r;
      int      kept;
      logic signed [DATA_W-1:0] held;

      r.data   = '0;
      r.status = ST_OK;
      case (w.action)
         ACT_PUSH_BACK: begin
            if (model_count >= DEPTH) begin
               // A full buffer drops the word and changes nothing.
               r.status = ST_FULL;
               full_refused++;
            end else begin
               model_ring[(model_head + model_count) % DEPTH] = w.value;
               model_count++;
            end
         end
         ACT_POP_BACK: begin
            if (model_count == 0) begin
               r.data   = EMPTY_WORD;
               r.status = ST_EMPTY;
               empty_pops++;
            end else begin
               model_count--;
               r.data = model_ring[(model_head + model_count) % DEPTH];
            end
         end
         ACT_POP_FRONT: begin
            if (model_count == 0) begin
               r.data   = EMPTY_WORD;
               r.status = ST_EMPTY;
               empty_pops++;
            end else begin
               r.data     = model_ring[model_head];
               model_head = (model_head + 1) % DEPTH;
               model_count--;
            end
         end
         default: begin
            // Remove every word equal to the value, packing the survivors
            // towards the front in their original order.
            kept = 0;
            for (int k = 0; k < model_count; k++) begin
               held = model_ring[(model_head + k) % DEPTH];
               if (held != w.value) begin
                  model_ring[(model_head + kept) % DEPTH] = held;
                  kept++;
               end
            end
            model_count = kept;
            removals++;
         end
      endcase
      if (model_count > max_count)
         max_count = model_count;
      r.fill   = FILL_W'(model_count);
      r.vacant = (model_count == 0);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      mismatches++;
      $display("%0t: response %0d, %s: got %0h, wanted %0h", $realtime, words_seen, what,
               got, want);
   endtask

   // Offer one request word and hold it until the block takes it. Start is
   // left high when no pause follows, so back-to-back words never see start
   // lowered and raised within the same time step.
   task automatic send_word(input action_type act, input logic signed [DATA_W-1:0] val);
      req_type w;
      int      gap;

      w.action    = act;
      w.value     = val;
      start       <= 1'b1;
      req_payload <= w;
      do
         @(posedge clock);
      while (busy);
      awaited_rsp = {awaited_rsp, apply_operation(w)};
      words_sent++;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering words and let every owed response come back, then keep
   // clocking so that a stray late strobe would still be caught.
   task automatic wait_drained();
      start <= 1'b0;
      while (awaited_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Values are drawn mostly from a small pool so that removals find
   // matches, with the extremes of the range in the pool as well.
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return '0;
         1:       return -32'sd1;
         2:       return 32'sh8000_0000;
         3:       return 32'sh7fff_ffff;
         4:       return 32'sd5;
         5:       return 32'sd42;
         default: return $urandom;
      endcase
   endfunction

   // Corners on a small buffer: pops and removal on an empty buffer, the
   // extreme words, a removal that matches twice and one that matches nothing.
   task automatic test_corners();
      send_word(ACT_POP_BACK,  32'sh7fff_ffff);
      send_word(ACT_POP_FRONT, 32'sh8000_0000);
      send_word(ACT_REMOVE,    -32'sd1);
      send_word(ACT_PUSH_BACK, 32'sh8000_0000);
      send_word(ACT_PUSH_BACK, 32'sh7fff_ffff);
      send_word(ACT_PUSH_BACK, -32'sd1);
      send_word(ACT_PUSH_BACK, '0);
      send_word(ACT_PUSH_BACK, -32'sd1);
      send_word(ACT_POP_FRONT, '0);
      send_word(ACT_REMOVE,    -32'sd1);
      send_word(ACT_REMOVE,    32'sd123);
      send_word(ACT_POP_BACK,  -32'sd1);
      send_word(ACT_POP_BACK,  '0);
      send_word(ACT_POP_FRONT, -32'sd1);
      send_word(ACT_POP_BACK,  32'sh5555_aaaa);
      send_word(ACT_REMOVE,    '0);
      wait_drained();
   endtask

   // Fill the buffer across the wrap point, push against a full buffer, filter it
   // while it wraps, then pop from the back and empty it from the front.
   task automatic test_full_and_wrap();
      repeat (40) send_word(ACT_PUSH_BACK, pick_value());
      repeat (30) send_word(ACT_POP_FRONT, $urandom);
      while (model_count < DEPTH)
         send_word(ACT_PUSH_BACK, ($urandom_range(3) == 0) ? 32'sd42 : $urandom);
      send_word(ACT_PUSH_BACK, 32'sh7fff_ffff);
      send_word(ACT_PUSH_BACK, 32'sh8000_0000);
      send_word(ACT_REMOVE,    32'sd42);
      repeat (3) send_word(ACT_POP_BACK, $urandom);
      while (model_count > 0)
         send_word(ACT_POP_FRONT, $urandom);
      send_word(ACT_POP_FRONT, $urandom);
      wait_drained();
   endtask

   // Random operations. The push share swings between high and low every
   // so often, so that the buffer both fills up and runs dry repeatedly.
   task automatic test_random(input int idle_pct, input int count);
      int push_pct;
      int r;

      sender_idle_pct = idle_pct;
      push_pct        = 50;
      for (int n = 0; n < count; n++) begin
         if (n % 128 == 0)
            push_pct = $urandom_range(1) ? 75 : 20;
         r = $urandom_range(99);
         if (r < push_pct)
            send_word(ACT_PUSH_BACK, pick_value());
         else if (r < push_pct + 8)
            send_word(ACT_REMOVE, pick_value());
         else if ($urandom_range(1))
            send_word(ACT_POP_BACK, $urandom);
         else
            send_word(ACT_POP_FRONT, $urandom);
      end
      wait_drained();
   endtask

   // Every strobed response is compared with the oldest owed one. Outputs
   // are sampled at the edge, before the block's own updates land.
   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_strobe) begin
         words_seen++;
         if (awaited_rsp.size() == 0) begin
            report_mismatch("unexpected response", rsp_payload.data, '0);
         end else begin
            want = awaited_rsp[0];
            awaited_rsp.delete(0);
            if (rsp_payload.data !== want.data)
               report_mismatch("data", rsp_payload.data, want.data);
            if (rsp_payload.status !== want.status)
               report_mismatch("status", DATA_W'(rsp_payload.status), DATA_W'(want.status));
            if (rsp_payload.fill !== want.fill)
               report_mismatch("fill", DATA_W'(rsp_payload.fill), DATA_W'(want.fill));
            if (rsp_payload.vacant !== want.vacant)
               report_mismatch("vacant", DATA_W'(rsp_payload.vacant),
                               DATA_W'(want.vacant));
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 33;
      test_corners();
      test_full_and_wrap();
      test_random(33, 520);
      test_random(62, 520);
      test_random(0, 520);

      if (awaited_rsp.size() != 0)
         report_mismatch("responses missing", '0, awaited_rsp.size());
      $display("Sent %0d request words and checked %0d responses, peak fill %0d.",
               words_sent, words_seen, max_count);
      $display("Saw %0d pushes refused as full, %0d pops on empty, %0d removals.",
               full_refused, empty_pops, removals);
      if (mismatches == 0) begin
         $display("double_ended_buffer_with_filter: match");
      end else begin
         $display("double_ended_buffer_with_filter: mismatch");
      end
      $finish;
   end

   // Guard against a hung handshake; far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("double_ended_buffer_with_filter: mismatch");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/debf_pkg.sv
src/debf_ring_ptr.sv
src/double_ended_buffer_with_filter.sv
tb/double_ended_buffer_with_filter_test.sv
